// File: rtl/fan_soft_start_ramp_sequencer_top_macros.svh
// ----------------------------------------------------------------------------
// fan soft-start sequencer assertion macros
// shared property forms for the checker
// ----------------------------------------------------------------------------
`ifndef FAN_SOFT_START_RAMP_SEQUENCER_TOP_MACROS_SVH
`define FAN_SOFT_START_RAMP_SEQUENCER_TOP_MACROS_SVH

// same-cycle implication
`define FSS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define FSS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/fss_pkg.sv
// ----------------------------------------------------------------------------
// fss_pkg
// shared types, register map and reset values of the fan soft-start sequencer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fss_pkg;

   localparam int DUTY_W  = 16;
   localparam int TICKS_W = 8;
   localparam int SEQ_W   = 9;
   localparam int ADDR_W  = 5;
   localparam int DATA_W  = 32;
   localparam int IDX_W   = 3;

   // register indexes, byte address is 4 * index
   localparam logic [IDX_W-1:0] REG_PWM_PERIOD      = 3'd0;
   localparam logic [IDX_W-1:0] REG_LOW_DUTY_THRESH = 3'd1;
   localparam logic [IDX_W-1:0] REG_DUTY_STEP       = 3'd2;
   localparam logic [IDX_W-1:0] REG_FAST_INTERVAL   = 3'd3;
   localparam logic [IDX_W-1:0] REG_SLOW_INTERVAL   = 3'd4;
   localparam logic [IDX_W-1:0] REG_POWER_ON_DELAY  = 3'd5;
   localparam logic [IDX_W-1:0] REG_POWER_OFF_DELAY = 3'd6;

   localparam logic [DUTY_W-1:0]  RST_PWM_PERIOD      = 16'd1600;
   localparam logic [DUTY_W-1:0]  RST_LOW_DUTY_THRESH = 16'd160;
   localparam logic [DUTY_W-1:0]  RST_DUTY_STEP       = 16'd16;
   localparam logic [TICKS_W-1:0] RST_FAST_INTERVAL   = 8'd1;
   localparam logic [TICKS_W-1:0] RST_SLOW_INTERVAL   = 8'd10;
   localparam logic [TICKS_W-1:0] RST_POWER_ON_DELAY  = 8'd5;
   localparam logic [TICKS_W-1:0] RST_POWER_OFF_DELAY = 8'd200;

   localparam logic [TICKS_W-1:0] TICKS_MAX = {TICKS_W{1'b1}};

   typedef struct packed {
      logic [DUTY_W-1:0]  pwm_period;
      logic [DUTY_W-1:0]  low_duty_threshold;
      logic [DUTY_W-1:0]  duty_step;
      logic [TICKS_W-1:0] fast_interval;
      logic [TICKS_W-1:0] slow_interval;
      logic [TICKS_W-1:0] power_on_delay;
      logic [TICKS_W-1:0] power_off_delay;
   } cfg_type;

   // power sequencer state as seen after the current item
   typedef struct packed {
      logic pwm_allowed;
      logic supply_on;
   } seq_status_type;

endpackage

`default_nettype wire

// File: rtl/fss_csr.sv
// ----------------------------------------------------------------------------
// fss_csr
// apb register file holding the ramp and sequencer settings
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fss_csr (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         psel,
   input  wire logic                         penable,
   input  wire logic                         pwrite,
   input  wire logic [fss_pkg::ADDR_W-1:0]   paddr,
   input  wire logic [fss_pkg::DATA_W-1:0]   pwdata,
   output logic      [fss_pkg::DATA_W-1:0]   prdata,
   output logic                              pready,
   output fss_pkg::cfg_type                  cfg
);

   fss_pkg::cfg_type             cfg_ff;
   fss_pkg::cfg_type             cfg_in;
   logic [fss_pkg::IDX_W-1:0]    idx;
   logic                         wr_en;

   assign idx    = paddr[fss_pkg::ADDR_W-1:2];
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (idx)
            fss_pkg::REG_PWM_PERIOD:      cfg_in.pwm_period         = pwdata[15:0];
            fss_pkg::REG_LOW_DUTY_THRESH: cfg_in.low_duty_threshold = pwdata[15:0];
            fss_pkg::REG_DUTY_STEP:       cfg_in.duty_step          = pwdata[15:0];
            fss_pkg::REG_FAST_INTERVAL:   cfg_in.fast_interval      = pwdata[7:0];
            fss_pkg::REG_SLOW_INTERVAL:   cfg_in.slow_interval      = pwdata[7:0];
            fss_pkg::REG_POWER_ON_DELAY:  cfg_in.power_on_delay     = pwdata[7:0];
            fss_pkg::REG_POWER_OFF_DELAY: cfg_in.power_off_delay    = pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         fss_pkg::REG_PWM_PERIOD:      prdata = {16'd0, cfg_ff.pwm_period};
         fss_pkg::REG_LOW_DUTY_THRESH: prdata = {16'd0, cfg_ff.low_duty_threshold};
         fss_pkg::REG_DUTY_STEP:       prdata = {16'd0, cfg_ff.duty_step};
         fss_pkg::REG_FAST_INTERVAL:   prdata = {24'd0, cfg_ff.fast_interval};
         fss_pkg::REG_SLOW_INTERVAL:   prdata = {24'd0, cfg_ff.slow_interval};
         fss_pkg::REG_POWER_ON_DELAY:  prdata = {24'd0, cfg_ff.power_on_delay};
         fss_pkg::REG_POWER_OFF_DELAY: prdata = {24'd0, cfg_ff.power_off_delay};
         default:                      prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pwm_period         <= fss_pkg::RST_PWM_PERIOD;
         cfg_ff.low_duty_threshold <= fss_pkg::RST_LOW_DUTY_THRESH;
         cfg_ff.duty_step          <= fss_pkg::RST_DUTY_STEP;
         cfg_ff.fast_interval      <= fss_pkg::RST_FAST_INTERVAL;
         cfg_ff.slow_interval      <= fss_pkg::RST_SLOW_INTERVAL;
         cfg_ff.power_on_delay     <= fss_pkg::RST_POWER_ON_DELAY;
         cfg_ff.power_off_delay    <= fss_pkg::RST_POWER_OFF_DELAY;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/fss_seq.sv
// ----------------------------------------------------------------------------
// fss_seq
// supply / pwm power sequencer stepped on slow ticks
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fss_seq (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  advance,
   input  wire logic                  tick_slow,
   input  wire logic                  run,
   input  wire fss_pkg::cfg_type      cfg,
   output fss_pkg::seq_status_type    status
);

   logic signed [fss_pkg::SEQ_W-1:0] count_ff;
   logic signed [fss_pkg::SEQ_W-1:0] count_in;
   logic signed [fss_pkg::SEQ_W-1:0] count_base;
   logic signed [fss_pkg::SEQ_W-1:0] on_limit;
   logic signed [fss_pkg::SEQ_W-1:0] off_limit;
   fss_pkg::seq_status_type          status_ff;
   fss_pkg::seq_status_type          status_in;

   assign on_limit  = $signed({1'b0, cfg.power_on_delay});
   assign off_limit = -$signed({1'b0, cfg.power_off_delay});

   always_comb begin
      count_in   = count_ff;
      status_in  = status_ff;
      count_base = count_ff;
      if (tick_slow) begin
         if (run) begin
            status_in.supply_on = 1'b1;
            // restart from zero if we were counting down
            if (count_ff < 0) begin
               count_base = '0;
            end
            if (count_base < on_limit) begin
               count_in = count_base + 9'sd1;
            end else begin
               count_in              = count_base;
               status_in.pwm_allowed = 1'b1;
            end
         end else begin
            status_in.pwm_allowed = 1'b0;
            if (count_ff > 0) begin
               count_base = '0;
            end
            if (count_base > off_limit) begin
               count_in = count_base - 9'sd1;
            end else begin
               count_in            = count_base;
               status_in.supply_on = 1'b0;
            end
         end
      end
   end

   assign status = status_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         status_ff <= '0;
      end else if (advance) begin
         count_ff  <= count_in;
         status_ff <= status_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/fss_ramp.sv
// ----------------------------------------------------------------------------
// fss_ramp
// duty slew limiter and compare clamp
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fss_ramp (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          advance,
   input  wire logic                          tick_fast,
   input  wire logic [fss_pkg::DUTY_W-1:0]    target,
   input  wire logic                          pwm_allowed,
   input  wire fss_pkg::cfg_type              cfg,
   output logic      [fss_pkg::DUTY_W-1:0]    duty_now,
   output logic      [fss_pkg::DUTY_W-1:0]    compare_value
);

   logic [fss_pkg::DUTY_W-1:0]  duty_ff;
   logic [fss_pkg::DUTY_W-1:0]  duty_in;
   logic [fss_pkg::TICKS_W-1:0] ticks_ff;
   logic [fss_pkg::TICKS_W-1:0] ticks_in;
   logic [fss_pkg::TICKS_W-1:0] ticks_inc;
   logic [fss_pkg::TICKS_W-1:0] interval;
   logic [fss_pkg::DUTY_W-1:0]  gap_up;
   logic [fss_pkg::DUTY_W-1:0]  gap_down;

   assign ticks_inc = (ticks_ff < fss_pkg::TICKS_MAX) ? ticks_ff + 8'd1 : ticks_ff;
   assign interval  = (duty_ff < cfg.low_duty_threshold) ? cfg.fast_interval
                                                         : cfg.slow_interval;
   assign gap_up    = target - duty_ff;
   assign gap_down  = duty_ff - target;

   always_comb begin
      duty_in  = duty_ff;
      ticks_in = ticks_ff;
      if (target == '0 || !pwm_allowed) begin
         duty_in  = '0;
         ticks_in = '0;
      end else if (duty_ff == target) begin
         ticks_in = '0;
      end else if (tick_fast) begin
         if (ticks_inc < interval) begin
            ticks_in = ticks_inc;
         end else begin
            ticks_in = '0;
            // last step lands on the target when the gap is under one step
            if (duty_ff < target) begin
               duty_in = (gap_up >= cfg.duty_step) ? duty_ff + cfg.duty_step : target;
            end else begin
               duty_in = (gap_down >= cfg.duty_step) ? duty_ff - cfg.duty_step : target;
            end
         end
      end
   end

   always_comb begin
      if (duty_in == '0) begin
         compare_value = '0;
      end else if (duty_in >= cfg.pwm_period) begin
         compare_value = cfg.pwm_period;
      end else begin
         compare_value = duty_in;
      end
   end

   assign duty_now = duty_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         duty_ff  <= '0;
         ticks_ff <= '0;
      end else if (advance) begin
         duty_ff  <= duty_in;
         ticks_ff <= ticks_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/fan_soft_start_ramp_sequencer_top.sv
// ----------------------------------------------------------------------------
// fan_soft_start_ramp_sequencer_top
// fan supply sequencer with pwm duty soft-start ramp, one result per item
//
//   channel | direction | handshake           | payload
//   req     | in        | req_valid/req_stall | tick_fast, tick_slow, target_duty
//   rsp     | out       | rsp_valid/rsp_stall | duty_now, compare_value,
//           |           |                     | pwm_enable, power_enable
//   csr     | in/out    | apb psel/penable    | seven settings registers
//
// one item per cycle sustained while rsp_stall is low; each item passes from the
// input register through sequencer, ramp and clamp logic into the result register
// rsp_stall holds the result register and backs up into the input register
// reset clears sequencer, ramp, both valid flags and loads register defaults
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fan_soft_start_ramp_sequencer_top (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic                         req_tick_fast,
   input  wire logic                         req_tick_slow,
   input  wire logic [fss_pkg::DUTY_W-1:0]   req_target_duty,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic      [fss_pkg::DUTY_W-1:0]   rsp_duty_now,
   output logic      [fss_pkg::DUTY_W-1:0]   rsp_compare_value,
   output logic                              rsp_pwm_enable,
   output logic                              rsp_power_enable,
   input  wire logic                         psel,
   input  wire logic                         penable,
   input  wire logic                         pwrite,
   input  wire logic [fss_pkg::ADDR_W-1:0]   paddr,
   input  wire logic [fss_pkg::DATA_W-1:0]   pwdata,
   output logic      [fss_pkg::DATA_W-1:0]   prdata,
   output logic                              pready
);

   fss_pkg::cfg_type              cfg;
   fss_pkg::seq_status_type       seq_status;

   logic                          in_valid_ff;
   logic                          in_valid_in;
   logic                          in_tick_fast_ff;
   logic                          in_tick_slow_ff;
   logic [fss_pkg::DUTY_W-1:0]    in_target_ff;
   logic                          out_valid_ff;
   logic                          out_valid_in;
   logic [fss_pkg::DUTY_W-1:0]    out_duty_ff;
   logic [fss_pkg::DUTY_W-1:0]    out_compare_ff;
   logic                          out_pwm_ff;
   logic                          out_power_ff;
   logic [fss_pkg::DUTY_W-1:0]    duty_now;
   logic [fss_pkg::DUTY_W-1:0]    compare_value;
   logic                          out_free;
   logic                          advance;
   logic                          accept;

   fss_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // handshake between input and result registers
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   fss_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .tick_slow (in_tick_slow_ff),
      .run       (in_target_ff != '0),
      .cfg       (cfg),
      .status    (seq_status)
   );

   fss_ramp u_ramp (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .tick_fast     (in_tick_fast_ff),
      .target        (in_target_ff),
      .pwm_allowed   (seq_status.pwm_allowed),
      .cfg           (cfg),
      .duty_now      (duty_now),
      .compare_value (compare_value)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_stall) begin
         out_valid_in = out_valid_ff;
      end else begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_tick_fast_ff <= req_tick_fast;
         in_tick_slow_ff <= req_tick_slow;
         in_target_ff    <= req_target_duty;
      end
      if (advance) begin
         out_duty_ff    <= duty_now;
         out_compare_ff <= compare_value;
         out_pwm_ff     <= seq_status.pwm_allowed;
         out_power_ff   <= seq_status.supply_on;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_duty_now      = out_duty_ff;
   assign rsp_compare_value = out_compare_ff;
   assign rsp_pwm_enable    = out_pwm_ff;
   assign rsp_power_enable  = out_power_ff;

endmodule

`default_nettype wire

// File: rtl/fss_checker.sv
// ----------------------------------------------------------------------------
// fss_checker
// port-level checks of the fan soft-start sequencer, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "fan_soft_start_ramp_sequencer_top_macros.svh"

module fss_checker (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         rsp_valid,
   input  wire logic                         rsp_stall,
   input  wire logic [fss_pkg::DUTY_W-1:0]   rsp_duty_now,
   input  wire logic [fss_pkg::DUTY_W-1:0]   rsp_compare_value,
   input  wire logic                         rsp_pwm_enable,
   input  wire logic                         rsp_power_enable
);

   // a stalled result item holds
   `FSS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_duty_now) && $stable(rsp_compare_value), "stalled result changed")

   // pwm is never allowed with the supply off
   `FSS_ASSERT_NOW(a_pwm_needs_power, clock, reset, rsp_valid && rsp_pwm_enable, rsp_power_enable, "pwm enabled with supply off")

   // duty is forced to zero while pwm is blocked
   `FSS_ASSERT_NOW(a_duty_zero_blocked, clock, reset, rsp_valid && !rsp_pwm_enable, rsp_duty_now == '0, "nonzero duty while pwm blocked")

   // the clamp never raises the compare above the duty
   `FSS_ASSERT_NOW(a_compare_clamp, clock, reset, rsp_valid, rsp_compare_value <= rsp_duty_now, "compare above duty")

endmodule

bind fan_soft_start_ramp_sequencer_top fss_checker u_fss_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_duty_now      (rsp_duty_now),
   .rsp_compare_value (rsp_compare_value),
   .rsp_pwm_enable    (rsp_pwm_enable),
   .rsp_power_enable  (rsp_power_enable)
);

`default_nettype wire
